// ===== hdl/serial_rgb_led_bit_encoder_top_defines.svh =====
// Assertion macros shared by the LED bit encoder RTL.
`ifndef SERIAL_RGB_LED_BIT_ENCODER_TOP_DEFINES_SVH
`define SERIAL_RGB_LED_BIT_ENCODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define SRGB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define SRGB_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRGB_ASSERT(lbl, clk, rst, prop, msg)
`define SRGB_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/srgb_pkg.sv =====
package srgb_pkg;

  localparam int DATA_BITS   = 24;
  localparam int SYM_CNT_W   = $clog2(DATA_BITS + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam int HIGH_W  = 10;
  localparam int LOW_W   = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 3;

  localparam logic [HIGH_W-1:0] ONE_HIGH_RST  = 10'd14;
  localparam logic [HIGH_W-1:0] ONE_LOW_RST   = 10'd9;
  localparam logic [HIGH_W-1:0] ZERO_HIGH_RST = 10'd6;
  localparam logic [HIGH_W-1:0] ZERO_LOW_RST  = 10'd14;
  localparam logic [LOW_W-1:0]  LATCH_RST     = 16'd112;

  typedef enum logic [INDEX_W-1:0] {
    REG_ONE_HIGH  = 3'd0,
    REG_ONE_LOW   = 3'd1,
    REG_ZERO_HIGH = 3'd2,
    REG_ZERO_LOW  = 3'd3,
    REG_LATCH     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [HIGH_W-1:0] one_high;
    logic [HIGH_W-1:0] one_low;
    logic [HIGH_W-1:0] zero_high;
    logic [HIGH_W-1:0] zero_low;
    logic [LOW_W-1:0]  latch;
  } timing_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] word;
    logic                 chain;
    logic                 frame_end;
  } pixel_entry_t;

endpackage

// ===== hdl/srgb_cfg.sv =====
module srgb_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srgb_pkg::ADDR_W-1:0] paddr,
  input  logic [srgb_pkg::DATA_W-1:0] pwdata,
  output logic [srgb_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output srgb_pkg::timing_t           timing
);
  import srgb_pkg::*;

  timing_t    regs;
  reg_index_t idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign timing = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.one_high  <= ONE_HIGH_RST;
      regs.one_low   <= ONE_LOW_RST;
      regs.zero_high <= ZERO_HIGH_RST;
      regs.zero_low  <= ZERO_LOW_RST;
      regs.latch     <= LATCH_RST;
    end else if (wr_en) begin
      // keep only the register's width, drop unknown indexes
      unique case (idx)
        REG_ONE_HIGH:  regs.one_high  <= pwdata[HIGH_W-1:0];
        REG_ONE_LOW:   regs.one_low   <= pwdata[HIGH_W-1:0];
        REG_ZERO_HIGH: regs.zero_high <= pwdata[HIGH_W-1:0];
        REG_ZERO_LOW:  regs.zero_low  <= pwdata[HIGH_W-1:0];
        REG_LATCH:     regs.latch     <= pwdata[LOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ONE_HIGH:  prdata = DATA_W'(regs.one_high);
      REG_ONE_LOW:   prdata = DATA_W'(regs.one_low);
      REG_ZERO_HIGH: prdata = DATA_W'(regs.zero_high);
      REG_ZERO_LOW:  prdata = DATA_W'(regs.zero_low);
      REG_LATCH:     prdata = DATA_W'(regs.latch);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hdl/srgb_front.sv =====
`include "serial_rgb_led_bit_encoder_top_defines.svh"

module srgb_front #(
  parameter int Depth = srgb_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             red,
  input  logic [7:0]             green,
  input  logic [7:0]             blue,
  input  logic                   chain,
  input  logic                   frame_end,
  output logic                   q_valid,
  output srgb_pkg::pixel_entry_t q_data,
  input  logic                   q_pop
);
  import srgb_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  pixel_entry_t  entries [Depth];
  pixel_entry_t  entry_in;
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;

  // transmit order: green, red, blue, each msb first
  assign entry_in.word      = {green, red, blue};
  assign entry_in.chain     = chain;
  assign entry_in.frame_end = frame_end;

  assign in_ready = (count != CntW'(Depth));
  assign q_valid  = (count != '0);
  assign q_data   = entries[rd_ptr];
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= entry_in;
    end
  end

  `SRGB_ASSERT(a_count_bound, clk, rst, count <= CntW'(Depth), "queue count beyond depth")

endmodule

// ===== hdl/srgb_back.sv =====
`include "serial_rgb_led_bit_encoder_top_defines.svh"

module srgb_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  srgb_pkg::pixel_entry_t               q_data,
  output logic                                 q_pop,
  input  srgb_pkg::timing_t                    timing,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 bit_value,
  output logic [srgb_pkg::HIGH_W-1:0]          high_cycles,
  output logic [srgb_pkg::LOW_W-1:0]           low_cycles,
  output logic                                 is_latch,
  output logic                                 chain_out,
  output logic                                 last_symbol
);
  import srgb_pkg::*;

  logic                 active;
  logic [DATA_BITS-1:0] sh;
  logic [SYM_CNT_W-1:0] cnt;
  logic                 cur_chain;
  logic                 cur_fe;

  logic slot_free;
  logic emit;
  logic latch_sym;
  logic cur_bit;
  logic sym_last;
  logic done;

  assign slot_free = !out_valid || out_ready;
  assign emit      = active && slot_free;
  assign latch_sym = (cnt == SYM_CNT_W'(DATA_BITS));
  assign cur_bit   = sh[DATA_BITS-1];
  assign sym_last  = latch_sym || ((cnt == SYM_CNT_W'(DATA_BITS - 1)) && !cur_fe);
  assign done      = emit && sym_last;
  // load the next pixel in the same cycle the last symbol leaves
  assign q_pop     = q_valid && (!active || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
      cnt       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (slot_free) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (emit) begin
        cnt <= cnt + 1'b1;
        if (sym_last) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sh        <= q_data.word;
      cur_chain <= q_data.chain;
      cur_fe    <= q_data.frame_end;
    end else if (emit) begin
      sh <= {sh[DATA_BITS-2:0], 1'b0};
    end
    if (emit) begin
      chain_out   <= cur_chain;
      last_symbol <= sym_last;
      is_latch    <= latch_sym;
      if (latch_sym) begin
        bit_value   <= 1'b0;
        high_cycles <= '0;
        low_cycles  <= timing.latch;
      end else if (cur_bit) begin
        bit_value   <= 1'b1;
        high_cycles <= timing.one_high;
        low_cycles  <= LOW_W'(timing.one_low);
      end else begin
        bit_value   <= 1'b0;
        high_cycles <= timing.zero_high;
        low_cycles  <= LOW_W'(timing.zero_low);
      end
    end
  end

  `SRGB_ASSERT(a_latch_last, clk, rst, out_valid && is_latch |-> last_symbol && (high_cycles == '0) && !bit_value, "latch symbol malformed")
  `SRGB_ASSERT(a_no_latch_cnt, clk, rst, active && !cur_fe |-> cnt < SYM_CNT_W'(DATA_BITS), "latch reached without frame end")
  `SRGB_ASSERT_NR(a_reset_idle, clk, rst |=> !out_valid && !active, "back end busy after reset")

endmodule

// ===== hdl/serial_rgb_led_bit_encoder_top.sv =====
// Serial RGB LED bit encoder.
// Pixel channel (in_valid/in_ready): red, green, blue, chain select and a
// frame_end flag. Symbol channel (out_valid/out_ready): one beat per line
// symbol, 24 data symbols green, red, blue msb first, each with the high and
// low times of a one or zero bit, then one latch symbol if frame_end is set.
// The final symbol of each pixel carries last_symbol.
// Timing registers sit on the APB port at byte addresses 0, 4, 8, 12, 16;
// pready is always high. Write them only while no pixel is in flight.
// A pixel beat passes through the queue, then loads the serialiser, and each
// symbol is registered onto the symbol channel. Throughput: one symbol per
// cycle while out_ready stays high; a line driver taking each symbol at line
// speed paces it.
// A small pixel queue lets the input side keep accepting while the
// serialiser works; in_ready drops only once the queue is full.
// When the receiver stalls, the symbol beat holds and the serialiser waits.
// Synchronous reset empties the queue, drops out_valid and restores the
// timing registers to their defaults.
module serial_rgb_led_bit_encoder_top #(
  parameter int QueueDepth = srgb_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srgb_pkg::ADDR_W-1:0] paddr,
  input  logic [srgb_pkg::DATA_W-1:0] pwdata,
  output logic [srgb_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  logic                        chain,
  input  logic                        frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        bit_value,
  output logic [srgb_pkg::HIGH_W-1:0] high_cycles,
  output logic [srgb_pkg::LOW_W-1:0]  low_cycles,
  output logic                        is_latch,
  output logic                        chain_out,
  output logic                        last_symbol
);
  import srgb_pkg::*;

  timing_t      timing;
  pixel_entry_t q_data;
  logic         q_valid;
  logic         q_pop;

  srgb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .timing  (timing)
  );

  srgb_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .chain     (chain),
    .frame_end (frame_end),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  srgb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .timing      (timing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bit_value   (bit_value),
    .high_cycles (high_cycles),
    .low_cycles  (low_cycles),
    .is_latch    (is_latch),
    .chain_out   (chain_out),
    .last_symbol (last_symbol)
  );

endmodule
